### sv/vertex_cache_hard_cluster_split_assert.svh
// Assertion macros for the vertex cache cluster split block.
// Taken in by the back end and the top level; expects clk_i and rst_ni in scope.
`ifndef VERTEX_CACHE_HARD_CLUSTER_SPLIT_ASSERT_SVH
`define VERTEX_CACHE_HARD_CLUSTER_SPLIT_ASSERT_SVH

// Property checked at every edge outside reset.
`define VCHCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent this cycle, consequent on the next edge.
`define VCHCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/vchcs_pkg.sv
// Shared types and constants for the vertex cache cluster split block.
// No dependencies.
package vchcs_pkg;

  localparam int unsigned CacheEntries = 16;
  localparam int unsigned StampW       = 32;
  localparam int unsigned VertW        = 16;
  localparam int unsigned FaceW        = 24;
  localparam int unsigned MissW        = 2;
  localparam int unsigned SlotWMax     = 20;

  localparam logic [StampW-1:0] StampInit  = StampW'(CacheEntries + 1);
  localparam logic [StampW-1:0] StampLimit = StampW'(CacheEntries);
  localparam logic [MissW-1:0]  AllMissed  = MissW'(3);

  // Queue depths between the parts
  localparam int unsigned MidDepth = 4;
  localparam int unsigned MidCntW  = $clog2(MidDepth + 1);
  localparam int unsigned OutDepth = 2;

  // Which of the three lookups of a triangle is issued next
  typedef enum logic [2:0] {
    LkA = 3'b001,
    LkB = 3'b010,
    LkC = 3'b100
  } lookup_e;

  typedef struct packed {
    logic [SlotWMax-1:0] slot_a;
    logic [SlotWMax-1:0] slot_b;
    logic [SlotWMax-1:0] slot_c;
    logic                mesh_start;
    logic [FaceW-1:0]    face;
  } tri_t;

  typedef struct packed {
    logic [MissW-1:0] miss_count;
    logic             cluster_begins;
    logic [FaceW-1:0] face_number;
  } res_t;

endpackage

### sv/vchcs_fifo.sv
// Small register queue, power-of-two depth, used between the parts.
// No package dependency.
module vchcs_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [Width-1:0]           data_i,
  input  logic                       pop_i,
  output logic [Width-1:0]           data_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(Depth+1)-1:0] count_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rd_ptr_q];
  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

### sv/vchcs_front.sv
// Front end: takes triangles, numbers faces, folds vertex indices onto slots.
// Uses vchcs_pkg; feeds the middle queue by credit on its fill count.
module vchcs_front #(
  parameter int unsigned VertexSlots = 65536
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  logic [vchcs_pkg::VertW-1:0]       vertex_a_i,
  input  logic [vchcs_pkg::VertW-1:0]       vertex_b_i,
  input  logic [vchcs_pkg::VertW-1:0]       vertex_c_i,
  input  logic                              mesh_start_i,
  input  logic [vchcs_pkg::MidCntW-1:0]     mid_count_i,
  output logic                              full_o,
  output logic                              push_o,
  output vchcs_pkg::tri_t                   item_o
);
  import vchcs_pkg::*;

  // index mod slots = v - q*slots, q estimated by reciprocal, one correction
  localparam int unsigned   RecipW  = 29;
  localparam logic [63:0]   Recip64 = (64'd1 << 32) / 64'(VertexSlots);
  localparam logic [RecipW-1:0] Recip = Recip64[RecipW-1:0];
  localparam int unsigned   ProdW   = VertW + RecipW;
  localparam int unsigned   QW      = ProdW - 32;
  localparam int unsigned   ModW    = SlotWMax + 1;
  localparam logic [ModW-1:0] Slots = ModW'(VertexSlots);

  logic [VertW-1:0] vin [3];
  logic [ProdW-1:0] prod [3];
  logic [ModW-1:0]  r_fix [3];

  logic             s1_valid_q, s2_valid_q;
  logic [VertW-1:0] s1_v_q [3];
  logic [QW-1:0]    s1_q_q [3];
  logic [ModW-1:0]  s2_r_q [3];
  logic             s1_start_q, s2_start_q;
  logic [FaceW-1:0] s1_face_q, s2_face_q;
  logic [FaceW-1:0] face_q, face_d, face_now;
  logic [MidCntW:0] in_flight;

  assign vin[0] = vertex_a_i;
  assign vin[1] = vertex_b_i;
  assign vin[2] = vertex_c_i;

  assign face_now = mesh_start_i ? '0 : face_q;
  assign face_d   = accept_i ? face_now + FaceW'(1) : face_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]  = ProdW'(vin[i]) * ProdW'(Recip);
      r_fix[i] = (s2_r_q[i] >= Slots) ? s2_r_q[i] - Slots : s2_r_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      face_q     <= '0;
    end else begin
      s1_valid_q <= accept_i;
      s2_valid_q <= s1_valid_q;
      face_q     <= face_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      s1_v_q[i] <= vin[i];
      s1_q_q[i] <= prod[i][ProdW-1:32];
      s2_r_q[i] <= ModW'(s1_v_q[i]) - ModW'(s1_q_q[i]) * Slots;
    end
    s1_start_q <= mesh_start_i;
    s1_face_q  <= face_now;
    s2_start_q <= s1_start_q;
    s2_face_q  <= s1_face_q;
  end

  // Items in the two stages are counted against the queue's room
  assign in_flight = (MidCntW+1)'(mid_count_i) + (MidCntW+1)'(s1_valid_q)
                   + (MidCntW+1)'(s2_valid_q);
  assign full_o    = (in_flight >= (MidCntW+1)'(MidDepth));

  assign push_o            = s2_valid_q;
  assign item_o.slot_a     = SlotWMax'(r_fix[0]);
  assign item_o.slot_b     = SlotWMax'(r_fix[1]);
  assign item_o.slot_c     = SlotWMax'(r_fix[2]);
  assign item_o.mesh_start = s2_start_q;
  assign item_o.face       = s2_face_q;

endmodule

### sv/vchcs_back.sv
// Back end: three timestamp lookups per triangle against the stamp memory.
// Uses vchcs_pkg and the assertion macros; clears the memory after reset.
`include "vertex_cache_hard_cluster_split_assert.svh"

module vchcs_back #(
  parameter int unsigned VertexSlots = 65536
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            mid_valid_i,
  input  vchcs_pkg::tri_t mid_item_i,
  output logic            mid_pop_o,
  input  logic            out_full_i,
  output logic            out_push_o,
  output vchcs_pkg::res_t out_item_o,
  output logic            clearing_o
);
  import vchcs_pkg::*;

  localparam int unsigned AW = $clog2(VertexSlots);
  localparam logic [AW-1:0] LastAddr = AW'(VertexSlots - 1);

  logic [StampW-1:0] stamp_mem [VertexSlots];
  logic [StampW-1:0] rdata_q;

  logic              clr_busy_q;
  logic [AW-1:0]     clr_addr_q;

  lookup_e           lk_q, lk_d;
  logic [AW-1:0]     issue_slot;
  logic              issue, stall, first_lk, last_lk;

  logic              c_valid_q, c_first_q, c_last_q, c_start_q;
  logic [AW-1:0]     c_slot_q;
  logic [FaceW-1:0]  c_face_q;

  logic              fwd_q;
  logic [StampW-1:0] fwd_stamp_q;
  logic [StampW-1:0] stored, age;
  logic              miss;

  logic [StampW-1:0] stamp_q, stamp_d;
  logic              add_start;
  logic [MissW-1:0]  acc_q, total;

  assign first_lk = (lk_q == LkA);
  assign last_lk  = (lk_q == LkC);

  always_comb begin
    case (lk_q)
      LkA:     issue_slot = mid_item_i.slot_a[AW-1:0];
      LkB:     issue_slot = mid_item_i.slot_b[AW-1:0];
      LkC:     issue_slot = mid_item_i.slot_c[AW-1:0];
      default: issue_slot = mid_item_i.slot_a[AW-1:0];
    endcase
  end

  // result waiting on a full output queue freezes both stages
  assign stall = c_valid_q && c_last_q && out_full_i;
  assign issue = mid_valid_i && !clr_busy_q && !stall;

  always_comb begin
    lk_d = lk_q;
    if (issue) begin
      case (lk_q)
        LkA:     lk_d = LkB;
        LkB:     lk_d = LkC;
        LkC:     lk_d = LkA;
        default: lk_d = LkA;
      endcase
    end
  end

  // compare stage; a slot written by the lookup just before is forwarded
  assign stored = fwd_q ? fwd_stamp_q : rdata_q;
  assign age    = stamp_q - stored;
  assign miss   = c_valid_q && (age > StampLimit);
  assign total  = (c_first_q ? '0 : acc_q) + MissW'(miss);

  assign add_start = issue && first_lk && mid_item_i.mesh_start;

  always_comb begin
    stamp_d = stamp_q;
    if (!stall) begin
      case ({miss, add_start})
        2'b10:   stamp_d = stamp_q + StampW'(1);
        2'b01:   stamp_d = stamp_q + StampInit;
        2'b11:   stamp_d = stamp_q + StampInit + StampW'(1);
        default: stamp_d = stamp_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
      lk_q       <= LkA;
      c_valid_q  <= 1'b0;
      fwd_q      <= 1'b0;
      stamp_q    <= StampInit;
      acc_q      <= '0;
    end else begin
      if (clr_busy_q) begin
        clr_addr_q <= clr_addr_q + AW'(1);
        if (clr_addr_q == LastAddr) begin
          clr_busy_q <= 1'b0;
        end
      end
      lk_q    <= lk_d;
      stamp_q <= stamp_d;
      if (!stall) begin
        c_valid_q <= issue;
        fwd_q     <= issue && miss && (c_slot_q == issue_slot);
        if (c_valid_q) begin
          acc_q <= total;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall) begin
      c_slot_q    <= issue_slot;
      c_first_q   <= first_lk;
      c_last_q    <= last_lk;
      c_start_q   <= mid_item_i.mesh_start;
      c_face_q    <= mid_item_i.face;
      fwd_stamp_q <= stamp_q;
    end
  end

  // stamp memory: one write and one registered read a cycle
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      stamp_mem[clr_addr_q] <= '0;
    end else if (!stall && miss) begin
      stamp_mem[c_slot_q] <= stamp_q;
    end
    if (issue) begin
      rdata_q <= stamp_mem[issue_slot];
    end
  end

  assign mid_pop_o                 = issue && last_lk;
  assign out_push_o                = c_valid_q && c_last_q && !out_full_i;
  assign out_item_o.miss_count     = total;
  assign out_item_o.cluster_begins = c_start_q || (total == AllMissed);
  assign out_item_o.face_number    = c_face_q;
  assign clearing_o                = clr_busy_q;

  `VCHCS_ASSERT(a_no_issue_clr, clr_busy_q |-> !issue, "lookup issued during clearing pass")
  `VCHCS_ASSERT_NEXT(a_stall_hold, stall, c_valid_q && c_last_q && $stable(c_slot_q) && $stable(acc_q), "compare stage moved under stall")
  `VCHCS_ASSERT_NEXT(a_fwd_set, issue && miss && (c_slot_q == issue_slot), fwd_q && (fwd_stamp_q == $past(stamp_q)), "same-slot forward lost")

endmodule

### sv/vertex_cache_hard_cluster_split.sv
// Path: an accepted item passes the front stages, the middle queue, the
// back end's issue and compare stages once per lookup, and the output queue.
// The three serial read-modify-write lookups of a triangle share the single
// timestamp memory; the next triangle's lookups may issue behind them.
// Reset: asynchronous, active low; then a clearing pass over all VertexSlots
// slots zeroes the timestamp memory, with full held high until it ends.
`include "vertex_cache_hard_cluster_split_assert.svh"

module vertex_cache_hard_cluster_split #(
  parameter int unsigned VertexSlots = 65536
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [vchcs_pkg::VertW-1:0]   vertex_a_i,
  input  logic [vchcs_pkg::VertW-1:0]   vertex_b_i,
  input  logic [vchcs_pkg::VertW-1:0]   vertex_c_i,
  input  logic                          mesh_start_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [vchcs_pkg::MissW-1:0]   miss_count_o,
  output logic                          cluster_begins_o,
  output logic [vchcs_pkg::FaceW-1:0]   face_number_o
);
  import vchcs_pkg::*;

  // Front end: face numbering and slot folding, two register stages.
  // Middle queue: decouples the front from the lookup engine; the front
  // only takes an item when the queue has room for everything in flight.
  // Back end: issue stage reads the stamp memory, compare stage decides
  // hit or miss and, on a miss, writes the stamp back and bumps the global stamp.
  // Output queue: lets the back end finish an item while a result waits.

  localparam int unsigned TriW = $bits(tri_t);
  localparam int unsigned ResW = $bits(res_t);
  localparam int unsigned OutCntW = $clog2(OutDepth + 1);

  logic                 accept;
  logic                 front_full, clearing;

  logic                 mid_push, mid_pop, mid_full, mid_empty;
  tri_t                 mid_in, mid_out;
  logic [TriW-1:0]      mid_out_raw;
  logic [MidCntW-1:0]   mid_count;

  logic                 out_push, out_pop, out_full, out_empty;
  res_t                 out_in, out_item;
  logic [ResW-1:0]      out_raw;
  logic [OutCntW-1:0]   out_count;

  // no item is taken while the stamp memory is being cleared
  assign full   = front_full || clearing;
  assign accept = push && !full;

  vchcs_front #(
    .VertexSlots(VertexSlots)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .vertex_a_i  (vertex_a_i),
    .vertex_b_i  (vertex_b_i),
    .vertex_c_i  (vertex_c_i),
    .mesh_start_i(mesh_start_i),
    .mid_count_i (mid_count),
    .full_o      (front_full),
    .push_o      (mid_push),
    .item_o      (mid_in)
  );

  vchcs_fifo #(
    .Width(TriW),
    .Depth(MidDepth)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (mid_push),
    .data_i (mid_in),
    .pop_i  (mid_pop),
    .data_o (mid_out_raw),
    .full_o (mid_full),
    .empty_o(mid_empty),
    .count_o(mid_count)
  );

  assign mid_out = tri_t'(mid_out_raw);

  vchcs_back #(
    .VertexSlots(VertexSlots)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_valid_i(!mid_empty),
    .mid_item_i (mid_out),
    .mid_pop_o  (mid_pop),
    .out_full_i (out_full),
    .out_push_o (out_push),
    .out_item_o (out_in),
    .clearing_o (clearing)
  );

  assign out_pop = pop && !empty;

  vchcs_fifo #(
    .Width(ResW),
    .Depth(OutDepth)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .data_i (out_in),
    .pop_i  (out_pop),
    .data_o (out_raw),
    .full_o (out_full),
    .empty_o(out_empty),
    .count_o(out_count)
  );

  assign out_item         = res_t'(out_raw);
  assign empty            = out_empty;
  assign miss_count_o     = out_item.miss_count;
  assign cluster_begins_o = out_item.cluster_begins;
  assign face_number_o    = out_item.face_number;

  `VCHCS_ASSERT(a_mid_room, mid_push |-> !mid_full, "middle queue overrun")
  `VCHCS_ASSERT(a_out_room, out_push |-> (out_count != OutCntW'(OutDepth)), "output queue overrun")

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for vertex_cache_hard_cluster_split: triangles go in
// through the push/full queue side and results come out through empty/pop.
// Depends on vchcs_pkg and the block itself; predicts results with its own model.
module tb;
  import vchcs_pkg::*;

  localparam int unsigned HalfPeriod = 2;
  localparam int unsigned RandTris   = 1950;
  localparam int unsigned NumDir     = 19;
  // Longer than the longest stall or gap; catches results left in the pipe.
  localparam int unsigned DrainWait  = 80;

  // One row of the directed stimulus. Where fixed is set, want is the result
  // read straight off the behaviour; otherwise the predictor supplies it.
  typedef struct packed {
    logic [VertW-1:0] a;
    logic [VertW-1:0] b;
    logic [VertW-1:0] c;
    logic             ms;
    logic             fixed;
    res_t             want;
  } dir_row_t;

  localparam dir_row_t DirRows [NumDir] = '{
    // fresh store after reset: every lookup misses, no mesh start needed
    '{16'd0,     16'd1,     16'd2,     1'b0, 1'b1, '{2'd3, 1'b1, 24'd0}},
    // same three straight away: all hit, numbering carries on
    '{16'd0,     16'd1,     16'd2,     1'b0, 1'b1, '{2'd0, 1'b0, 24'd1}},
    // top index three times: only the first lookup misses
    '{16'hFFFF,  16'hFFFF,  16'hFFFF,  1'b0, 1'b1, '{2'd1, 1'b0, 24'd2}},
    '{16'd0,     16'hFFFF,  16'd3,     1'b0, 1'b0, '0},
    // mesh start empties the cache, whatever was stored
    '{16'hAAAA,  16'h5555,  16'hFFFF,  1'b1, 1'b1, '{2'd3, 1'b1, 24'd0}},
    '{16'h5555,  16'hAAAA,  16'h1234,  1'b0, 1'b0, '0},
    // mesh start with one vertex repeated: one miss, still a new cluster
    '{16'd7,     16'd7,     16'd7,     1'b1, 1'b1, '{2'd1, 1'b1, 24'd0}},
    '{16'd7,     16'd8,     16'd7,     1'b0, 1'b0, '0},
    // eighteen fresh vertices push 7 and 8 out of the window
    '{16'd100,   16'd101,   16'd102,   1'b0, 1'b0, '0},
    '{16'd103,   16'd104,   16'd105,   1'b0, 1'b0, '0},
    '{16'd106,   16'd107,   16'd108,   1'b0, 1'b0, '0},
    '{16'd109,   16'd110,   16'd111,   1'b0, 1'b0, '0},
    '{16'd112,   16'd113,   16'd114,   1'b0, 1'b0, '0},
    '{16'd115,   16'd116,   16'd117,   1'b0, 1'b0, '0},
    // all three miss without a mesh start: cluster split by misses alone
    '{16'd7,     16'd8,     16'd9,     1'b0, 1'b0, '0},
    '{16'd100,   16'd101,   16'd102,   1'b1, 1'b1, '{2'd3, 1'b1, 24'd0}},
    '{16'd100,   16'd101,   16'd102,   1'b0, 1'b0, '0},
    '{16'd102,   16'd200,   16'd101,   1'b0, 1'b0, '0},
    '{16'd0,     16'd0,     16'hFFFF,  1'b0, 1'b0, '0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             push;
  logic             full;
  logic [VertW-1:0] vertex_a_i;
  logic [VertW-1:0] vertex_b_i;
  logic [VertW-1:0] vertex_c_i;
  logic             mesh_start_i;
  logic             empty;
  logic             pop;
  logic [MissW-1:0] miss_count_o;
  logic             cluster_begins_o;
  logic [FaceW-1:0] face_number_o;

  vertex_cache_hard_cluster_split uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .vertex_a_i      (vertex_a_i),
    .vertex_b_i      (vertex_b_i),
    .vertex_c_i      (vertex_c_i),
    .mesh_start_i    (mesh_start_i),
    .empty           (empty),
    .pop             (pop),
    .miss_count_o    (miss_count_o),
    .cluster_begins_o(cluster_begins_o),
    .face_number_o   (face_number_o)
  );

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always #(HalfPeriod) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Cache predictor: stamp per vertex, running stamp, face number
  // --------------------------------------------------------------------------
  logic [StampW-1:0] vert_stamp [1 << VertW];
  logic [StampW-1:0] stamp_now;
  logic [FaceW-1:0]  face_next;

  res_t        results_due [$];  // oldest first
  int unsigned mismatch_count;
  int unsigned tris_sent;
  int unsigned mesh_starts;
  int unsigned results_checked;
  int unsigned splits_seen;

  function automatic void clear_cache_model();
    foreach (vert_stamp[i]) vert_stamp[i] = '0;
    stamp_now = StampInit;
    face_next = '0;
  endfunction

  // One lookup; a miss stamps the vertex and moves the stamp on, so the next
  // lookup of the same triangle already sees it.
  function automatic logic probe_vertex(input logic [VertW-1:0] v);
    logic [StampW-1:0] age;
    age = stamp_now - vert_stamp[v];
    if (age > StampLimit) begin
      vert_stamp[v] = stamp_now;
      stamp_now     = stamp_now + StampW'(1);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic res_t predict_triangle(input logic [VertW-1:0] a, b, c,
                                            input logic ms);
    res_t             r;
    logic [MissW-1:0] misses;
    logic [FaceW-1:0] face;
    // a mesh start ages every stored stamp past the window instead of clearing
    if (ms) begin
      stamp_now = stamp_now + StampW'(CacheEntries + 1);
      face      = '0;
    end else begin
      face = face_next;
    end
    misses = '0;
    misses = misses + MissW'(probe_vertex(a));
    misses = misses + MissW'(probe_vertex(b));
    misses = misses + MissW'(probe_vertex(c));
    face_next          = face + FaceW'(1);
    r.miss_count       = misses;
    r.cluster_begins   = ms || (misses == AllMissed);
    r.face_number      = face;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("[%0t] %s: got %0d, expected %0d", $realtime, field, got, want);
    mismatch_count++;
  endtask

  // Gap length: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  // --------------------------------------------------------------------------
  // Sender side. Holds push high from one item to the next when there is no
  // gap, so push never gets two assignments in one step.
  // --------------------------------------------------------------------------
  task automatic send_triangle(input logic [VertW-1:0] a, b, c, input logic ms,
                               input int unsigned gap);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    vertex_a_i   <= a;
    vertex_b_i   <= b;
    vertex_c_i   <= c;
    mesh_start_i <= ms;
    do @(posedge clk_i); while (full);
    tris_sent++;
    if (ms) mesh_starts++;
  endtask

  // --------------------------------------------------------------------------
  // Receiver side: checks each result taken and drives pop with stalls
  // --------------------------------------------------------------------------
  int unsigned pop_hold;
  int unsigned rx_cycles;
  bit          pop_calm;

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      if (pop && !empty) begin
        if (results_due.size() == 0) begin
          $display("[%0t] result with nothing outstanding", $realtime);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          results_checked++;
          if (cluster_begins_o === 1'b1) splits_seen++;
          if (miss_count_o !== want.miss_count)
            report_mismatch("miss_count", 32'(miss_count_o), 32'(want.miss_count));
          if (cluster_begins_o !== want.cluster_begins)
            report_mismatch("cluster_begins", 32'(cluster_begins_o),
                            32'(want.cluster_begins));
          if (face_number_o !== want.face_number)
            report_mismatch("face_number", 32'(face_number_o), 32'(want.face_number));
        end
      end
      // calm or stalling is redrawn from rx_cycles; a quarter of the draws give no stalls
      rx_cycles++;
      if (rx_cycles % 512 == 0) pop_calm = ($urandom_range(0, 3) == 0);
      if (pop_hold != 0) begin
        pop_hold--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        if (!pop_calm && $urandom_range(0, 99) < 30) pop_hold = pick_gap(1'b0);
      end
    end else begin
      pop <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [VertW-1:0] prev [3];
    logic [VertW-1:0] va, vb, vc;
    logic [VertW-1:0] window;
    logic             ms;
    res_t             guess;
    bit               tx_calm;
    int unsigned      kind;

    push         <= 1'b0;
    vertex_a_i   <= '0;
    vertex_b_i   <= '0;
    vertex_c_i   <= '0;
    mesh_start_i <= 1'b0;
    rst_ni       <= 1'b0;
    mismatch_count  = 0;
    tris_sent       = 0;
    mesh_starts     = 0;
    results_checked = 0;
    splits_seen     = 0;
    pop_hold        = 0;
    rx_cycles       = 0;
    pop_calm        = 1'b0;
    tx_calm         = 1'b0;
    clear_cache_model();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows; the block holds full through its clearing pass, so the
    // first push simply waits for it.
    for (int i = 0; i < NumDir; i++) begin
      send_triangle(DirRows[i].a, DirRows[i].b, DirRows[i].c, DirRows[i].ms,
                    pick_gap(1'b0));
      guess = predict_triangle(DirRows[i].a, DirRows[i].b, DirRows[i].c, DirRows[i].ms);
      results_due.push_back(DirRows[i].fixed ? DirRows[i].want : guess);
    end

    // Random triangles. Mostly strips and small windows so hits and partial
    // misses dominate; some full-range noise, repeats and extreme indices.
    prev[0] = 16'd100;
    prev[1] = 16'd101;
    prev[2] = 16'd102;
    window  = 16'($urandom);
    for (int n = 0; n < RandTris; n++) begin
      if (n % 64 == 0) tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 49) == 0) window = 16'($urandom);
      ms   = ($urandom_range(0, 99) < 4);
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        // strip: shares an edge with the previous triangle
        va = prev[1];
        vb = prev[2];
        vc = prev[2] + 16'($urandom_range(1, 4));
      end else if (kind < 70) begin
        va = window + 16'($urandom_range(0, 23));
        vb = window + 16'($urandom_range(0, 23));
        vc = window + 16'($urandom_range(0, 23));
      end else if (kind < 88) begin
        va = 16'($urandom);
        vb = 16'($urandom);
        vc = 16'($urandom);
      end else if (kind < 94) begin
        // repeated vertex in some position
        va = window + 16'($urandom_range(0, 7));
        vb = ($urandom_range(0, 1) == 1) ? va : window + 16'($urandom_range(0, 7));
        vc = ($urandom_range(0, 1) == 1) ? va : vb;
      end else begin
        va = ($urandom_range(0, 2) == 0) ? 16'h0000 :
             ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'($urandom);
        vb = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'h0000;
        vc = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
      end
      send_triangle(va, vb, vc, ms, pick_gap(tx_calm));
      results_due.push_back(predict_triangle(va, vb, vc, ms));
      prev[0] = va;
      prev[1] = vb;
      prev[2] = vc;
    end
    push <= 1'b0;

    // Drain, then give stray results time to show up
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);

    $display("Sent %0d triangles with %0d mesh starts; %0d results checked,",
             tris_sent, mesh_starts, results_checked);
    $display("%0d of them opening a new cluster.", splits_seen);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Watchdog: clearing pass plus slowest plausible run, several times over
  // --------------------------------------------------------------------------
  initial begin
    #4000000;
    $display("Timeout with %0d results outstanding", results_due.size());
    $display("Mismatches found");
    $finish;
  end

endmodule

### vertex_cache_hard_cluster_split.f
+incdir+sv
sv/vchcs_pkg.sv
sv/vchcs_fifo.sv
sv/vchcs_front.sv
sv/vchcs_back.sv
sv/vertex_cache_hard_cluster_split.sv
tb/sv/tb.sv
